// ===== src/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

   // Decoder modes
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_STR     = 3'd1,
      MODE_ESC     = 3'd2,
      MODE_HEX     = 3'd3,
      MODE_HIGH    = 3'd4,
      MODE_PAIR_U  = 3'd5,
      MODE_LOW_HEX = 3'd6
   } jsu_mode_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } jsu_kind_type;

   localparam int unsigned MaxResults = 4;

   // Source characters
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   // Control characters produced by the simple escapes
   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_CR = 8'h0D;
   localparam logic [7:0] CTL_HT = 8'h09;

   // Surrogate ranges
   localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SUR_LO  = 16'hDC00;
   localparam logic [15:0] LOW_SUR_HI  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;

   // Up to four results of one source byte, in order
   typedef struct packed {
      logic [2:0]                count;
      jsu_kind_type [3:0]        kind;
      logic [3:0][7:0]           data;
   } jsu_burst_type;

   typedef struct packed {
      logic [2:0]       len;
      logic [3:0][7:0]  data;
   } jsu_utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } jsu_hex_type;

   // Encode one code point as UTF-8, first byte in slot 0
   function automatic jsu_utf8_type utf8_encode(input logic [20:0] cp);
      jsu_utf8_type enc;
      enc = '0;
      if (cp < 21'h80) begin
         enc.len     = 3'd1;
         enc.data[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         enc.len     = 3'd2;
         enc.data[0] = 8'hC0 | {3'b000, cp[10:6]};
         enc.data[1] = 8'h80 | {2'b00, cp[5:0]};
      end else if (cp < 21'h10000) begin
         enc.len     = 3'd3;
         enc.data[0] = 8'hE0 | {4'b0000, cp[15:12]};
         enc.data[1] = 8'h80 | {2'b00, cp[11:6]};
         enc.data[2] = 8'h80 | {2'b00, cp[5:0]};
      end else begin
         enc.len     = 3'd4;
         enc.data[0] = 8'hF0 | {5'b00000, cp[20:18]};
         enc.data[1] = 8'h80 | {2'b00, cp[17:12]};
         enc.data[2] = 8'h80 | {2'b00, cp[11:6]};
         enc.data[3] = 8'h80 | {2'b00, cp[5:0]};
      end
      return enc;
   endfunction

   // Hex digit in either case
   function automatic jsu_hex_type hex_decode(input logic [7:0] b);
      jsu_hex_type h;
      h = '0;
      if (b inside {[8'h30:8'h39]}) begin
         h.ok    = 1'b1;
         h.value = b[3:0];
      end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         h.ok    = 1'b1;
         h.value = b[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

// ===== src/jsu_req_if.sv =====
`default_nettype none

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== src/jsu_rsp_if.sv =====
`default_nettype none

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output kind, output out_byte, output last, input ready);
   modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== src/jsu_decode.sv =====
`default_nettype none

module jsu_decode (
   input  wire logic                   clock,
   input  wire logic                   reset,
   jsu_req_if.sink                     req_ch,
   input  wire logic                   burst_free,
   output jsu_pkg::jsu_burst_type      burst,
   output logic                        burst_load
);
   import jsu_pkg::*;

   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   logic          in_eoi_ff;

   jsu_mode_type  mode_ff, mode_in;
   logic [1:0]    digit_cnt_ff, digit_cnt_in;
   logic [15:0]   acc_ff, acc_in;
   logic [15:0]   pend_ff, pend_in;

   jsu_hex_type   hex;
   logic [15:0]   acc_next;
   logic [20:0]   pair_cp;
   jsu_utf8_type  enc;
   logic          advance;

   // Decode the held byte against the current mode
   always_comb begin
      mode_in      = mode_ff;
      digit_cnt_in = digit_cnt_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      burst        = '0;
      hex          = hex_decode(in_byte_ff);
      acc_next     = {acc_ff[11:0], hex.value};
      pair_cp      = SUPP_BASE + {1'b0, pend_ff[9:0], acc_next[9:0]};
      enc          = '0;

      if (in_eoi_ff) begin
         if (mode_ff inside {MODE_STR, MODE_ESC, MODE_HEX, MODE_HIGH, MODE_PAIR_U,
                             MODE_LOW_HEX}) begin
            burst.count   = 3'd1;
            burst.kind[0] = KIND_ERR;
            digit_cnt_in  = 2'd0;
         end
         mode_in = MODE_IDLE;
      end else begin
         case (mode_ff)
            MODE_STR: begin
               if (in_byte_ff == CH_QUOTE) begin
                  burst.count   = 3'd1;
                  burst.kind[0] = KIND_END;
                  mode_in       = MODE_IDLE;
               end else if (in_byte_ff == CH_BSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  burst.count   = 3'd1;
                  burst.data[0] = in_byte_ff;
               end
            end
            MODE_ESC: begin
               mode_in       = MODE_STR;
               burst.count   = 3'd1;
               case (in_byte_ff)
                  CH_QUOTE:  burst.data[0] = CH_QUOTE;
                  CH_BSLASH: burst.data[0] = CH_BSLASH;
                  CH_SLASH:  burst.data[0] = CH_SLASH;
                  CH_B:      burst.data[0] = CTL_BS;
                  CH_F:      burst.data[0] = CTL_FF;
                  CH_N:      burst.data[0] = CTL_LF;
                  CH_R:      burst.data[0] = CTL_CR;
                  CH_T:      burst.data[0] = CTL_HT;
                  CH_U: begin
                     burst.count  = 3'd0;
                     mode_in      = MODE_HEX;
                     digit_cnt_in = 2'd0;
                     acc_in       = '0;
                  end
                  default: begin
                     burst.kind[0] = KIND_ERR;
                     mode_in       = MODE_IDLE;
                     digit_cnt_in  = 2'd0;
                  end
               endcase
            end
            MODE_HEX, MODE_LOW_HEX: begin
               if (!hex.ok) begin
                  burst.count   = 3'd1;
                  burst.kind[0] = KIND_ERR;
                  mode_in       = MODE_IDLE;
                  digit_cnt_in  = 2'd0;
               end else begin
                  acc_in = acc_next;
                  if (digit_cnt_ff != 2'd3) begin
                     digit_cnt_in = digit_cnt_ff + 2'd1;
                  end else begin
                     digit_cnt_in = 2'd0;
                     if (mode_ff == MODE_HEX) begin
                        if (acc_next >= HIGH_SUR_LO && acc_next <= HIGH_SUR_HI) begin
                           pend_in = acc_next;
                           mode_in = MODE_HIGH;
                        end else begin
                           enc         = utf8_encode({5'd0, acc_next});
                           burst.count = enc.len;
                           burst.data  = enc.data;
                           mode_in     = MODE_STR;
                        end
                     end else if (acc_next < LOW_SUR_LO || acc_next > LOW_SUR_HI) begin
                        burst.count   = 3'd1;
                        burst.kind[0] = KIND_ERR;
                        mode_in       = MODE_IDLE;
                     end else begin
                        enc         = utf8_encode(pair_cp);
                        burst.count = enc.len;
                        burst.data  = enc.data;
                        mode_in     = MODE_STR;
                     end
                  end
               end
            end
            MODE_HIGH: begin
               if (in_byte_ff == CH_BSLASH) begin
                  mode_in = MODE_PAIR_U;
               end else begin
                  // Lone high surrogate: three bytes, then the byte or, on a quote, an end marker
                  enc        = utf8_encode({5'd0, pend_ff});
                  burst.data = enc.data;
                  if (in_byte_ff == CH_QUOTE) begin
                     burst.count   = 3'd4;
                     burst.kind[3] = KIND_END;
                     burst.data[3] = 8'h00;
                     mode_in       = MODE_IDLE;
                  end else begin
                     burst.count   = 3'd4;
                     burst.data[3] = in_byte_ff;
                     mode_in       = MODE_STR;
                  end
               end
            end
            MODE_PAIR_U: begin
               if (in_byte_ff == CH_U) begin
                  mode_in      = MODE_LOW_HEX;
                  digit_cnt_in = 2'd0;
                  acc_in       = '0;
               end else begin
                  burst.count   = 3'd1;
                  burst.kind[0] = KIND_ERR;
                  mode_in       = MODE_IDLE;
                  digit_cnt_in  = 2'd0;
               end
            end
            default: begin
               // Idle: only an opening quote starts a string
               if (in_byte_ff == CH_QUOTE) begin
                  mode_in = MODE_STR;
               end else begin
                  burst.count   = 3'd1;
                  burst.kind[0] = KIND_ERR;
                  mode_in       = MODE_IDLE;
                  digit_cnt_in  = 2'd0;
               end
            end
         endcase
      end
   end

   // A byte that yields nothing advances even while a burst drains
   assign advance    = in_valid_ff && (burst.count == 3'd0 || burst_free);
   assign burst_load = advance && (burst.count != 3'd0);
   assign req_ch.ready = !in_valid_ff || advance;

   // Hold the input item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.in_byte;
         in_eoi_ff  <= req_ch.end_of_input;
      end
   end

   // Advance the decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         digit_cnt_ff <= 2'd0;
         acc_ff       <= '0;
         pend_ff      <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         digit_cnt_ff <= digit_cnt_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/jsu_burst.sv =====
`default_nettype none

module jsu_burst (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire jsu_pkg::jsu_burst_type burst,
   input  wire logic                   burst_load,
   output logic                        burst_free,
   jsu_rsp_if.source                   rsp_ch
);
   import jsu_pkg::*;

   logic [2:0]          count_ff;
   logic [1:0]          idx_ff;
   jsu_kind_type [3:0]  kind_ff;
   logic [3:0][7:0]     data_ff;
   logic                at_end;
   logic                take;

   assign at_end = (count_ff - 3'd1) == {1'b0, idx_ff};
   assign take   = rsp_ch.valid && rsp_ch.ready;
   assign burst_free = (count_ff == 3'd0) || (take && at_end);

   // Present the current slot
   assign rsp_ch.valid    = count_ff != 3'd0;
   assign rsp_ch.kind     = kind_ff[idx_ff];
   assign rsp_ch.out_byte = data_ff[idx_ff];
   assign rsp_ch.last     = at_end;

   // Load a new burst or step through the held one
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         idx_ff   <= 2'd0;
      end else if (burst_load && burst_free) begin
         count_ff <= burst.count;
         idx_ff   <= 2'd0;
      end else if (take) begin
         if (at_end) begin
            count_ff <= 3'd0;
            idx_ff   <= 2'd0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (burst_load && burst_free) begin
         kind_ff <= burst.kind;
         data_ff <= burst.data;
      end
   end

endmodule

`default_nettype wire

// ===== src/json_string_unescape_utf8_top.sv =====
// Path: an item's first result is shown once the item has passed the input
// register and then the output burst register.
// Throughput: one item per cycle while each item yields at most one result and
// the result port is not stalled; an item that yields more holds the result
// port one byte each, and the single output burst register sets that rate.
// Reset: synchronous, active high; clears the decoder to idle and empties both
// the input register and the output burst register.
`default_nettype none

module json_string_unescape_utf8_top (
   input  wire logic clock,
   input  wire logic reset,
   jsu_req_if.sink   req_ch,
   jsu_rsp_if.source rsp_ch
);
   import jsu_pkg::*;

   jsu_burst_type burst;
   logic          burst_load;
   logic          burst_free;

   jsu_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .burst_free (burst_free),
      .burst      (burst),
      .burst_load (burst_load)
   );

   jsu_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .burst      (burst),
      .burst_load (burst_load),
      .burst_free (burst_free),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== src/jsu_checker.sv =====
`default_nettype none

module jsu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last
);
   import jsu_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled result changed");

   // Only the three defined kinds appear
   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_DATA || rsp_kind == KIND_END || rsp_kind == KIND_ERR))
      else $error("undefined result kind");

   // End and error markers carry a zero byte and close the item's results
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DATA |-> rsp_last && rsp_out_byte == 8'h00)
      else $error("marker without last or with a byte");

   // Nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_kind     (rsp_ch.kind),
   .rsp_out_byte (rsp_ch.out_byte),
   .rsp_last     (rsp_ch.last)
);

`default_nettype wire
